// ===== design/mhie_pkg.sv =====
// ----------------------------------------------------------------------------
// mhie_pkg: shared types and constants of the max-heap insert engine
// Heap sizing, field widths and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mhie_pkg;

  localparam int CAPACITY = 128;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SLOT_W   = $clog2(CAPACITY);

  localparam int KEY_W    = 16;
  localparam int TAG_W    = 16;
  localparam int COUNT_OW = 8;
  localparam int SLOT_OW  = 7;

  localparam int IN_W     = KEY_W + TAG_W;
  localparam int OUT_W    = 16;

  typedef struct packed {
    logic load;      // capture input item, start at the next free slot
    logic rd_first;  // read the parent of the current slot
    logic rd_next;   // read the grandparent of the current slot
    logic move;      // write the parent down into the current slot, climb
    logic place;     // write the new entry at the current slot
    logic emit;      // load the result register
  } mhie_cmd_t;

  typedef struct packed {
    logic acc;       // item is being inserted (heap was not full)
    logic pos_zero;  // current slot is the root
    logic up_zero;   // parent of the current slot is the root
    logic greater;   // new key is strictly above the parent key just read
  } mhie_stat_t;

endpackage

`default_nettype wire

// ===== design/mhie_dp.sv =====
// ----------------------------------------------------------------------------
// mhie_dp: heap storage and sift-up datapath
// Holds the heap memory, entry count, the climbing slot and the result
// register; acts on commands from the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module mhie_dp (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [mhie_pkg::IN_W-1:0]  in_data,
  input  wire mhie_pkg::mhie_cmd_t     cmd,
  output mhie_pkg::mhie_stat_t         stat,
  output logic [mhie_pkg::OUT_W-1:0]   out_data
);
  import mhie_pkg::*;

  logic [KEY_W+TAG_W-1:0] mem [CAPACITY];

  logic [CNT_W-1:0]       count;
  logic [SLOT_W-1:0]      pos;
  logic [SLOT_W-1:0]      up;
  logic [SLOT_W-1:0]      up2;
  logic [KEY_W-1:0]       new_key;
  logic [TAG_W-1:0]       new_tag;
  logic                   acc;
  logic [KEY_W+TAG_W-1:0] rd_data;
  logic [SLOT_W-1:0]      rd_addr;
  logic                   full;

  assign full    = (count >= CNT_W'(CAPACITY));
  assign up      = SLOT_W'((pos - SLOT_W'(1)) >> 1);
  assign up2     = SLOT_W'((up - SLOT_W'(1)) >> 1);
  assign rd_addr = cmd.rd_first ? up : up2;

  assign stat.acc      = acc;
  assign stat.pos_zero = (pos == '0);
  assign stat.up_zero  = (up == '0);
  assign stat.greater  = (new_key > rd_data[KEY_W-1:0]);

  // Memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.move) begin
      mem[pos] <= rd_data;
    end else if (cmd.place) begin
      mem[pos] <= {new_tag, new_key};
    end
    if (cmd.rd_first || cmd.rd_next) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.place) begin
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      new_key <= in_data[KEY_W-1:0];
      new_tag <= in_data[KEY_W+TAG_W-1:KEY_W];
      acc     <= !full;
      pos     <= full ? '0 : count[SLOT_W-1:0];
    end else if (cmd.move) begin
      pos <= up;
    end
    if (cmd.emit) begin
      out_data <= {(acc ? SLOT_OW'(pos) : SLOT_OW'(0)), COUNT_OW'(count), acc};
    end
  end

endmodule

`default_nettype wire

// ===== design/mhie_ctrl.sv =====
// ----------------------------------------------------------------------------
// mhie_ctrl: insert sequencer
// Steps one item through capture, parent reads, swaps and final placement,
// and owns the handshake flags of both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module mhie_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  input  wire mhie_pkg::mhie_stat_t stat,
  output mhie_pkg::mhie_cmd_t       cmd
);
  import mhie_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_CMP   = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!stat.acc) begin
          state_next = ST_FIN;
        end else if (stat.pos_zero) begin
          cmd.place  = 1'b1;
          state_next = ST_FIN;
        end else begin
          cmd.rd_first = 1'b1;
          state_next   = ST_CMP;
        end
      end
      ST_CMP: begin
        if (stat.greater) begin
          // swap down, then either finish at the root or read one level up
          cmd.move = 1'b1;
          if (stat.up_zero) begin
            state_next = ST_CHECK;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end else begin
          cmd.place  = 1'b1;
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/max_heap_insert_engine.sv =====
// ----------------------------------------------------------------------------
// max_heap_insert_engine: binary max-heap insert unit
// Inserts key/tag entries into a max-heap of CAPACITY slots by sift-up and
// reports where each entry landed.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Bits  Contents (low bit first)
//  s_*       in   32    key[15:0], tag[31:16]
//  m_*       out  16    accepted[0], new_count[8:1], landed_slot[15:9]
//
//  m_tvalid rises after an accepted insert has climbed its L levels (at
//  most 7 for 128 slots), one parent read and one swap write per level;
//  an insert into the empty heap or a dropped item climbs no level.
//  Reset clears the entry count and control only; heap slots need no reset
//  since only slots below the count are ever read.
//  One item is in flight at a time; a result stalled on m_tready holds the
//  sequencer at its final step, and input is taken again once it is loaded.
//
`default_nettype none

module max_heap_insert_engine (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [mhie_pkg::IN_W-1:0]  s_tdata,   // key[15:0], tag[31:16]
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [mhie_pkg::OUT_W-1:0]      m_tdata    // accepted, new_count, landed_slot
);
  import mhie_pkg::*;

  mhie_cmd_t  cmd;
  mhie_stat_t stat;

  // Sequencer: one transaction in, walk the levels, one transaction out
  mhie_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Heap memory, count, climbing slot and result register
  mhie_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (s_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (m_tdata)
  );

endmodule

`default_nettype wire

// ===== design/mhie_chk.sv =====
// ----------------------------------------------------------------------------
// mhie_chk: port-level checks of the max-heap insert engine
// Watches both streams and the result fields over time.
// ----------------------------------------------------------------------------
`default_nettype none

module mhie_chk (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       s_tvalid,
  input wire logic                       s_tready,
  input wire logic [mhie_pkg::IN_W-1:0]  s_tdata,
  input wire logic                       m_tvalid,
  input wire logic                       m_tready,
  input wire logic [mhie_pkg::OUT_W-1:0] m_tdata
);
  import mhie_pkg::*;

  logic [IN_W-1:0] unused_in;
  assign unused_in = s_tdata;

  // One item at a time: after an input transaction the block is busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken again right after a transaction");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Dropped items report slot zero
  a_drop_slot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[15:9] == 7'd0)
    else $error("dropped item reports a nonzero slot");

  // An inserted entry lands inside the occupied part of the heap
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> {1'b0, m_tdata[15:9]} < m_tdata[8:1])
    else $error("landed slot outside the occupied heap");

endmodule

bind max_heap_insert_engine mhie_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
